// ----- rtl/core/tnl_pkg.sv -----
// Package for the twist norm limiter: widths, register map, cell data types
// and the output saturation function. No dependencies.
package tnl_pkg;

	// Fixed-point format and field widths
	localparam int FRAC_BITS = 16;
	localparam int DATA_W    = 32;
	localparam int CFG_W     = 31;
	localparam int THR_W     = 16;
	localparam int MAG_W     = DATA_W;
	localparam int RBITS     = 32;
	localparam int R_W       = RBITS + 1;

	// Scaled linear magnitude, split into two halves for its square
	localparam int M_W    = MAG_W + CFG_W - FRAC_BITS;
	localparam int HALF_W = (M_W + 1) / 2;
	localparam int HI_W   = M_W - HALF_W;
	localparam int MSQ_W  = 2 * M_W;
	localparam int ASQ_W  = 2 * MAG_W;
	localparam int ASUM_W = ASQ_W + 2;
	localparam int TOT_W  = MSQ_W + 2;
	localparam int LIM2_W = 2 * CFG_W;

	// Square root cells: one root bit per cell
	localparam int SQ_IN_W  = TOT_W + (TOT_W % 2);
	localparam int ROOT_W   = SQ_IN_W / 2;
	localparam int SQ_REM_W = ROOT_W + 1;

	// Divide cells: one quotient bit per cell
	localparam int DIV_REM_W = ROOT_W + 1;
	localparam int NUM_W     = DATA_W + FRAC_BITS;

	// Configuration port
	localparam int ADDR_W = 4;
	localparam int PDATA_W = 32;
	localparam logic [1:0] REG_NORM_LIMIT = 2'd0;
	localparam logic [1:0] REG_CHAR_LENGTH = 2'd1;
	localparam logic [1:0] REG_SMALL_THR = 2'd2;

	// Square root cell data
	typedef struct packed {
		logic [SQ_IN_W-1:0]  rad;
		logic [SQ_REM_W-1:0] rem;
		logic [ROOT_W-1:0]   root;
	} sq_t;

	// Divide cell data
	typedef struct packed {
		logic [DIV_REM_W-1:0] rem;
		logic [NUM_W-1:0]     num;
		logic [NUM_W-1:0]     q;
		logic [ROOT_W-1:0]    d;
	} div_t;

	// Restore sign and saturate to the signed output range
	function automatic logic [DATA_W-1:0] sat_pack(input logic neg, input logic [NUM_W-1:0] mag);
		logic [NUM_W-1:0] lim;
		logic [DATA_W-1:0] m;
		begin
			if (neg) begin
				lim = NUM_W'(1) << (DATA_W - 1);
				m = (mag > lim) ? lim[DATA_W-1:0] : mag[DATA_W-1:0];
				sat_pack = ~m + DATA_W'(1);
			end else begin
				lim = (NUM_W'(1) << (DATA_W - 1)) - NUM_W'(1);
				m = (mag > lim) ? lim[DATA_W-1:0] : mag[DATA_W-1:0];
				sat_pack = m;
			end
		end
	endfunction

endpackage

// ----- rtl/core/tnl_if.sv -----
// Channel interfaces of the twist norm limiter: input twist and limited twist.
// Depends on tnl_pkg for field widths.
interface tnl_in_if;
	logic valid;
	logic ready;
	logic signed [tnl_pkg::DATA_W-1:0] lin_x;
	logic signed [tnl_pkg::DATA_W-1:0] lin_y;
	logic signed [tnl_pkg::DATA_W-1:0] lin_z;
	logic signed [tnl_pkg::DATA_W-1:0] ang_x;
	logic signed [tnl_pkg::DATA_W-1:0] ang_y;
	logic signed [tnl_pkg::DATA_W-1:0] ang_z;
	modport source(output valid, lin_x, lin_y, lin_z, ang_x, ang_y, ang_z, input ready);
	modport sink(input valid, lin_x, lin_y, lin_z, ang_x, ang_y, ang_z, output ready);
endinterface

interface tnl_out_if;
	logic valid;
	logic ready;
	logic signed [tnl_pkg::DATA_W-1:0] out_lin_x;
	logic signed [tnl_pkg::DATA_W-1:0] out_lin_y;
	logic signed [tnl_pkg::DATA_W-1:0] out_lin_z;
	logic signed [tnl_pkg::DATA_W-1:0] out_ang_x;
	logic signed [tnl_pkg::DATA_W-1:0] out_ang_y;
	logic signed [tnl_pkg::DATA_W-1:0] out_ang_z;
	logic was_limited;
	modport source(output valid, out_lin_x, out_lin_y, out_lin_z, out_ang_x, out_ang_y,
		out_ang_z, was_limited, input ready);
	modport sink(input valid, out_lin_x, out_lin_y, out_lin_z, out_ang_x, out_ang_y,
		out_ang_z, was_limited, output ready);
endinterface

// ----- rtl/core/twist_norm_limiter.sv -----
// Twist norm limiter top level: front end, square root and divide cell chains,
// scaling and saturation. Depends on tnl_pkg, tnl_if, tnl_sqrt_cell, tnl_div_cell.
//
//  channel | dir | handshake        | payload
//  in_ch   | in  | valid/ready      | lin_x..ang_z, signed Q16.16
//  out_ch  | out | valid/ready      | out_lin_x..out_ang_z, was_limited
//  apb     | in  | psel/penable     | norm_limit, char_length, small_threshold
//
// One twist per cycle while the output is not stalled; at 16 fraction bits the pipeline is
// 5 front stages + 48 root cells + 33 ratio cells + 2 scale stages + 48 fallback cells
// + output register. The latency is set by the length of the cell chains.
// Reset clears valid bits and loads the register defaults; no clearing pass.
// A stalled output holds the whole pipeline; ready follows the output register.
module twist_norm_limiter (
	input  logic                          clk,
	input  logic                          arst_n,
	tnl_in_if.sink                        in_ch,
	tnl_out_if.source                     out_ch,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [tnl_pkg::ADDR_W-1:0]    paddr,
	input  logic [tnl_pkg::PDATA_W-1:0]   pwdata,
	output logic [tnl_pkg::PDATA_W-1:0]   prdata,
	output logic                          pready
);
	localparam int MAG_W  = tnl_pkg::MAG_W;
	localparam int ROOT_W = tnl_pkg::ROOT_W;
	localparam int R_W    = tnl_pkg::R_W;
	localparam int NUM_W  = tnl_pkg::NUM_W;
	localparam int P_W    = MAG_W + R_W;
	localparam int RA_W   = R_W + tnl_pkg::DATA_W;

	typedef struct packed {
		logic [5:0]            neg;
		logic [5:0][MAG_W-1:0] mag;
		logic                  limited;
	} side_t;

	typedef struct packed {
		side_t                       s;
		logic [tnl_pkg::DATA_W-1:0]  a;
	} rside_t;

	typedef struct packed {
		logic [5:0]            neg;
		logic [5:0][MAG_W-1:0] mag;
		logic [5:0][MAG_W-1:0] sm;
		logic                  main;
		logic                  limited;
	} tail_t;

	// configuration registers
	logic [tnl_pkg::CFG_W-1:0] norm_limit_q;
	logic [tnl_pkg::CFG_W-1:0] char_length_q;
	logic [tnl_pkg::THR_W-1:0] small_thr_q;
	logic cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			norm_limit_q  <= tnl_pkg::CFG_W'(1) << tnl_pkg::FRAC_BITS;
			char_length_q <= tnl_pkg::CFG_W'(1) << tnl_pkg::FRAC_BITS;
			small_thr_q   <= tnl_pkg::THR_W'(7);
		end else if (cfg_wr) begin
			case (paddr[3:2])
				tnl_pkg::REG_NORM_LIMIT:  norm_limit_q  <= pwdata[tnl_pkg::CFG_W-1:0];
				tnl_pkg::REG_CHAR_LENGTH: char_length_q <= pwdata[tnl_pkg::CFG_W-1:0];
				tnl_pkg::REG_SMALL_THR:   small_thr_q   <= pwdata[tnl_pkg::THR_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			tnl_pkg::REG_NORM_LIMIT:  prdata = tnl_pkg::PDATA_W'(norm_limit_q);
			tnl_pkg::REG_CHAR_LENGTH: prdata = tnl_pkg::PDATA_W'(char_length_q);
			tnl_pkg::REG_SMALL_THR:   prdata = tnl_pkg::PDATA_W'(small_thr_q);
			default:                  prdata = '0;
		endcase
	end

	// pipeline advance
	logic en;
	logic out_valid_q;
	assign en = !out_valid_q || out_ch.ready;
	assign in_ch.ready = en;

	// valid bits
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;
	logic [ROOT_W-1:0] v_sq;
	logic [R_W-1:0]    v_dr;
	logic [NUM_W-1:0]  v_fb;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_sq <= '0;
			v_dr <= '0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_fb <= '0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			v_s1 <= in_ch.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_sq <= {v_sq[ROOT_W-2:0], v_s5};
			v_dr <= {v_dr[R_W-2:0], v_sq[ROOT_W-1]};
			v_s6 <= v_dr[R_W-1];
			v_s7 <= v_s6;
			v_fb <= {v_fb[NUM_W-2:0], v_s7};
			out_valid_q <= v_fb[NUM_W-1];
		end
	end

	// s1: capture the twist
	logic [5:0][tnl_pkg::DATA_W-1:0] din_s1;
	always_ff @(posedge clk) begin
		if (en) begin
			din_s1[0] <= in_ch.lin_x;
			din_s1[1] <= in_ch.lin_y;
			din_s1[2] <= in_ch.lin_z;
			din_s1[3] <= in_ch.ang_x;
			din_s1[4] <= in_ch.ang_y;
			din_s1[5] <= in_ch.ang_z;
		end
	end

	// s2: sign and magnitude, linear scaling and angular squares
	logic [5:0]            neg_c;
	logic [5:0][MAG_W-1:0] mag_c;
	side_t side_s2, side_s3, side_s4, side_s5;
	logic [2:0][MAG_W+tnl_pkg::CFG_W-1:0] lprod_s2;
	logic [2:0][tnl_pkg::ASQ_W-1:0]       asq_s2;

	always_comb begin
		for (int i = 0; i < 6; i++) begin
			neg_c[i] = din_s1[i][tnl_pkg::DATA_W-1];
			mag_c[i] = neg_c[i] ? (~din_s1[i] + MAG_W'(1)) : din_s1[i];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s2.neg <= neg_c;
			side_s2.mag <= mag_c;
			side_s2.limited <= 1'b0;
			for (int i = 0; i < 3; i++) begin
				lprod_s2[i] <= (MAG_W + tnl_pkg::CFG_W)'(mag_c[i])
					* (MAG_W + tnl_pkg::CFG_W)'(char_length_q);
				asq_s2[i] <= tnl_pkg::ASQ_W'(mag_c[i+3]) * tnl_pkg::ASQ_W'(mag_c[i+3]);
			end
		end
	end

	// s3: truncate scaled magnitude, partial products of its square, angular sum, squared limit
	logic [2:0][tnl_pkg::M_W-1:0]      m_c;
	logic [2:0][2*tnl_pkg::HALF_W-1:0] ll_s3;
	logic [2:0][tnl_pkg::M_W-1:0]      lh_s3;
	logic [2:0][2*tnl_pkg::HI_W-1:0]   hh_s3;
	logic [tnl_pkg::ASUM_W-1:0]        asum_s3, asum_s4, asum_s5;
	logic [tnl_pkg::LIM2_W-1:0]        lim2_s3, lim2_s4;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			m_c[i] = lprod_s2[i][MAG_W+tnl_pkg::CFG_W-1:tnl_pkg::FRAC_BITS];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s3 <= side_s2;
			for (int i = 0; i < 3; i++) begin
				ll_s3[i] <= (2*tnl_pkg::HALF_W)'(m_c[i][tnl_pkg::HALF_W-1:0])
					* (2*tnl_pkg::HALF_W)'(m_c[i][tnl_pkg::HALF_W-1:0]);
				lh_s3[i] <= tnl_pkg::M_W'(m_c[i][tnl_pkg::HALF_W-1:0])
					* tnl_pkg::M_W'(m_c[i][tnl_pkg::M_W-1:tnl_pkg::HALF_W]);
				hh_s3[i] <= (2*tnl_pkg::HI_W)'(m_c[i][tnl_pkg::M_W-1:tnl_pkg::HALF_W])
					* (2*tnl_pkg::HI_W)'(m_c[i][tnl_pkg::M_W-1:tnl_pkg::HALF_W]);
			end
			asum_s3 <= tnl_pkg::ASUM_W'(asq_s2[0]) + tnl_pkg::ASUM_W'(asq_s2[1])
				+ tnl_pkg::ASUM_W'(asq_s2[2]);
			lim2_s3 <= tnl_pkg::LIM2_W'(norm_limit_q) * tnl_pkg::LIM2_W'(norm_limit_q);
		end
	end

	// s4: assemble linear squares
	logic [2:0][tnl_pkg::MSQ_W-1:0] msq_s4;
	always_ff @(posedge clk) begin
		if (en) begin
			side_s4 <= side_s3;
			asum_s4 <= asum_s3;
			lim2_s4 <= lim2_s3;
			for (int i = 0; i < 3; i++) begin
				msq_s4[i] <= (tnl_pkg::MSQ_W'(hh_s3[i]) << (2*tnl_pkg::HALF_W))
					+ (tnl_pkg::MSQ_W'(lh_s3[i]) << (tnl_pkg::HALF_W + 1))
					+ tnl_pkg::MSQ_W'(ll_s3[i]);
			end
		end
	end

	// s5: total square norm and limit compare
	logic [tnl_pkg::TOT_W-1:0] total_c, total_s5;
	logic limited_c;
	always_comb begin
		total_c = tnl_pkg::TOT_W'(msq_s4[0]) + tnl_pkg::TOT_W'(msq_s4[1])
			+ tnl_pkg::TOT_W'(msq_s4[2]) + tnl_pkg::TOT_W'(asum_s4);
		limited_c = total_c > tnl_pkg::TOT_W'(lim2_s4);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			total_s5 <= total_c;
			asum_s5 <= asum_s4;
			side_s5.neg <= side_s4.neg;
			side_s5.mag <= side_s4.mag;
			side_s5.limited <= limited_c;
		end
	end

	// square root chains: full norm and angular norm
	tnl_pkg::sq_t sqn_c [ROOT_W+1];
	tnl_pkg::sq_t sqa_c [ROOT_W+1];
	side_t side_sq [ROOT_W];

	always_comb begin
		sqn_c[0].rad = tnl_pkg::SQ_IN_W'(total_s5);
		sqn_c[0].rem = '0;
		sqn_c[0].root = '0;
		sqa_c[0].rad = tnl_pkg::SQ_IN_W'(asum_s5);
		sqa_c[0].rem = '0;
		sqa_c[0].root = '0;
	end

	for (genvar k = 0; k < ROOT_W; k++) begin : g_sq
		tnl_sqrt_cell u_sqn (.clk(clk), .en(en), .d_in(sqn_c[k]), .d_out(sqn_c[k+1]));
		tnl_sqrt_cell u_sqa (.clk(clk), .en(en), .d_in(sqa_c[k]), .d_out(sqa_c[k+1]));
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_sq[0] <= side_s5;
			for (int k = 1; k < ROOT_W; k++) begin
				side_sq[k] <= side_sq[k-1];
			end
		end
	end

	// ratio chain: r = limit * 2^32 / norm
	tnl_pkg::div_t dr_c [R_W+1];
	rside_t rside [R_W];

	always_comb begin
		dr_c[0].rem = tnl_pkg::DIV_REM_W'(norm_limit_q >> 1);
		dr_c[0].num = NUM_W'({norm_limit_q[0], tnl_pkg::RBITS'(0)}) << (NUM_W - R_W);
		dr_c[0].q = '0;
		dr_c[0].d = (sqn_c[ROOT_W].root == '0) ? ROOT_W'(1) : sqn_c[ROOT_W].root;
	end

	for (genvar k = 0; k < R_W; k++) begin : g_dr
		tnl_div_cell u_dr (.clk(clk), .en(en), .d_in(dr_c[k]), .d_out(dr_c[k+1]));
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rside[0].s <= side_sq[ROOT_W-1];
			rside[0].a <= sqa_c[ROOT_W].root[tnl_pkg::DATA_W-1:0];
			for (int k = 1; k < R_W; k++) begin
				rside[k] <= rside[k-1];
			end
		end
	end

	// s6: scale each component and the angular norm by r
	logic [R_W-1:0] r_c;
	logic [5:0][P_W-1:0] prod_s6;
	logic [RA_W-1:0] ra_s6;
	logic [tnl_pkg::DATA_W-1:0] a_s6;
	side_t side_s6;

	assign r_c = dr_c[R_W].q[R_W-1:0];

	always_ff @(posedge clk) begin
		if (en) begin
			side_s6 <= rside[R_W-1].s;
			a_s6 <= rside[R_W-1].a;
			ra_s6 <= RA_W'(r_c) * RA_W'(rside[R_W-1].a);
			for (int i = 0; i < 6; i++) begin
				prod_s6[i] <= P_W'(rside[R_W-1].s.mag[i]) * P_W'(r_c);
			end
		end
	end

	// s7: truncate products, pick main or fallback case
	tail_t tail_s7;
	always_ff @(posedge clk) begin
		if (en) begin
			tail_s7.neg <= side_s6.neg;
			tail_s7.mag <= side_s6.mag;
			tail_s7.limited <= side_s6.limited;
			tail_s7.main <= (ra_s6 > (RA_W'(small_thr_q) << tnl_pkg::RBITS))
				&& (a_s6 > tnl_pkg::DATA_W'(small_thr_q));
			for (int i = 0; i < 6; i++) begin
				tail_s7.sm[i] <= prod_s6[i][tnl_pkg::RBITS+MAG_W-1:tnl_pkg::RBITS];
			end
		end
	end

	// fallback chains: angular values divided by the length
	tnl_pkg::div_t fb_c [3][NUM_W+1];
	tail_t tail_fb [NUM_W];
	logic [ROOT_W-1:0] cl_div;

	assign cl_div = (char_length_q == '0) ? ROOT_W'(1) : ROOT_W'(char_length_q);

	for (genvar j = 0; j < 3; j++) begin : g_fb
		always_comb begin
			fb_c[j][0].rem = '0;
			fb_c[j][0].num = NUM_W'(tail_s7.sm[j+3]) << tnl_pkg::FRAC_BITS;
			fb_c[j][0].q = '0;
			fb_c[j][0].d = cl_div;
		end
		for (genvar k = 0; k < NUM_W; k++) begin : g_cell
			tnl_div_cell u_fb (.clk(clk), .en(en), .d_in(fb_c[j][k]), .d_out(fb_c[j][k+1]));
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tail_fb[0] <= tail_s7;
			for (int k = 1; k < NUM_W; k++) begin
				tail_fb[k] <= tail_fb[k-1];
			end
		end
	end

	// output register: select, restore sign, saturate
	tail_t t_end;
	logic [5:0][NUM_W-1:0] sel_c;
	logic [5:0][tnl_pkg::DATA_W-1:0] out_q;
	logic lim_q;

	assign t_end = tail_fb[NUM_W-1];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			sel_c[i] = t_end.limited ? NUM_W'(t_end.sm[i]) : NUM_W'(t_end.mag[i]);
			if (!t_end.limited) begin
				sel_c[i+3] = NUM_W'(t_end.mag[i+3]);
			end else if (t_end.main) begin
				sel_c[i+3] = NUM_W'(t_end.sm[i+3]);
			end else begin
				sel_c[i+3] = fb_c[i][NUM_W].q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			lim_q <= t_end.limited;
			for (int i = 0; i < 6; i++) begin
				out_q[i] <= tnl_pkg::sat_pack(t_end.neg[i], sel_c[i]);
			end
		end
	end

	assign out_ch.valid = out_valid_q;
	assign out_ch.out_lin_x = out_q[0];
	assign out_ch.out_lin_y = out_q[1];
	assign out_ch.out_lin_z = out_q[2];
	assign out_ch.out_ang_x = out_q[3];
	assign out_ch.out_ang_y = out_q[4];
	assign out_ch.out_ang_z = out_q[5];
	assign out_ch.was_limited = lim_q;

	// checks on the cell chains and on the stalled output
	a_root_rem: assert property (@(posedge clk) disable iff (!arst_n)
		v_sq[ROOT_W-1] |-> (tnl_pkg::SQ_REM_W'(sqn_c[ROOT_W].rem)
			<= {sqn_c[ROOT_W].root, 1'b0}))
		else $error("norm root remainder out of range");

	a_ratio_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(v_dr[R_W-1] && rside[R_W-1].s.limited) |->
			(dr_c[R_W].q <= (NUM_W'(1) << tnl_pkg::RBITS)))
		else $error("ratio above one");

	a_fb_rem: assert property (@(posedge clk) disable iff (!arst_n)
		v_fb[NUM_W-1] |-> (fb_c[0][NUM_W].rem < tnl_pkg::DIV_REM_W'(fb_c[0][NUM_W].d)))
		else $error("fallback divide remainder not below divisor");

	a_limit_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ch.ready) |=> (out_valid_q && $stable(lim_q)))
		else $error("stalled result changed");
endmodule

// ----- rtl/core/tnl_sqrt_cell.sv -----
// One cell of the square root chain: resolves one root bit per stage.
// Depends on tnl_pkg (sq_t).
module tnl_sqrt_cell (
	input  logic          clk,
	input  logic          en,
	input  tnl_pkg::sq_t  d_in,
	output tnl_pkg::sq_t  d_out
);
	logic [tnl_pkg::SQ_REM_W+1:0] cur;
	logic [tnl_pkg::SQ_REM_W+1:0] trial;
	logic [tnl_pkg::SQ_REM_W+1:0] diff;
	logic ge;
	tnl_pkg::sq_t nxt;

	// bring down two radicand bits, try root*4+1
	always_comb begin
		cur = {d_in.rem, d_in.rad[tnl_pkg::SQ_IN_W-1 -: 2]};
		trial = (tnl_pkg::SQ_REM_W + 2)'({d_in.root, 2'b01});
		ge = (cur >= trial);
		diff = cur - trial;
		nxt.rad = d_in.rad << 2;
		nxt.rem = ge ? diff[tnl_pkg::SQ_REM_W-1:0] : cur[tnl_pkg::SQ_REM_W-1:0];
		nxt.root = {d_in.root[tnl_pkg::ROOT_W-2:0], ge};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_out <= nxt;
		end
	end
endmodule

// ----- rtl/core/tnl_div_cell.sv -----
// One cell of a restoring divide chain: one quotient bit per stage.
// Depends on tnl_pkg (div_t).
module tnl_div_cell (
	input  logic          clk,
	input  logic          en,
	input  tnl_pkg::div_t d_in,
	output tnl_pkg::div_t d_out
);
	logic [tnl_pkg::DIV_REM_W:0] cur;
	logic [tnl_pkg::DIV_REM_W:0] dext;
	logic [tnl_pkg::DIV_REM_W:0] diff;
	logic ge;
	tnl_pkg::div_t nxt;

	// shift in next dividend bit, subtract divisor when it fits
	always_comb begin
		cur = {d_in.rem, d_in.num[tnl_pkg::NUM_W-1]};
		dext = (tnl_pkg::DIV_REM_W + 1)'(d_in.d);
		ge = (cur >= dext);
		diff = cur - dext;
		nxt.rem = ge ? diff[tnl_pkg::DIV_REM_W-1:0] : cur[tnl_pkg::DIV_REM_W-1:0];
		nxt.num = d_in.num << 1;
		nxt.q = {d_in.q[tnl_pkg::NUM_W-2:0], ge};
		nxt.d = d_in.d;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_out <= nxt;
		end
	end
endmodule
